// ===== rtl/pst_pkg.sv =====
// Package for the power supervisor tick block: item and result types,
// button modes, standby causes, event codes and register indexes. No dependencies.
package pst_pkg;

	localparam int TICKS_PER_SECOND_DEF  = 1000;
	localparam int SHORT_PRESS_MIN_DEF   = 40;
	localparam int LONG_PRESS_MIN_DEF    = 3000;
	localparam int SLOW_HALF_PERIOD_DEF  = 500;
	localparam int FAST_HALF_PERIOD_DEF  = 100;
	localparam int BUTTON_ACTIVE_LOW_DEF = 0;

	localparam int TPS_W   = 20;          // holds any tick rate up to one million
	localparam int SEC_W   = 16;
	localparam int LIM_W   = SEC_W + TPS_W;
	localparam int ELAP_W  = 27;
	localparam int TIMER_W = 12;
	localparam int CFG_IDX_W = 3;

	localparam logic [SEC_W-1:0] LOWBAT_RESET_S = SEC_W'(60);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WATCHDOG_TIMEOUT = 3'd0,
		CFG_LOWBAT_TIMEOUT   = 3'd1,
		CFG_EN_BUS_WATCHDOG  = 3'd2,
		CFG_EN_PIN_WATCHDOG  = 3'd3,
		CFG_EN_LOWBAT_SHDN   = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_PRESSED = 2'd1,
		MODE_HELD    = 2'd2
	} button_mode_t;

	typedef enum logic [1:0] {
		CAUSE_NONE       = 2'd0,
		CAUSE_LONG_PRESS = 2'd1,
		CAUSE_WATCHDOG   = 2'd2,
		CAUSE_LOWBAT     = 2'd3
	} standby_cause_t;

	typedef enum logic [1:0] {
		EVENT_NONE  = 2'd0,
		EVENT_SHORT = 2'd1,
		EVENT_LONG  = 2'd2
	} button_event_t;

	typedef struct packed {
		logic button_level;
		logic power_good;
		logic charger_stat1;
		logic charger_stat2;
		logic power_good2;
		logic clock_initialized;
		logic alarm_flag;
		logic bus_write_event;
		logic bus_read_event;
		logic watchdog_pin;
		logic clear_button_request;
	} item_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic       status_led;
		logic       power_led;
		logic       charge_led;
		logic       power_enable;
		logic       standby_request;
		logic [1:0] standby_cause;
		logic [1:0] button_event;
	} result_t;

endpackage

// ===== rtl/power_supervisor_tick_top.sv =====
// Top level of the power supervisor tick block: input register, tick logic,
// result register and configuration registers. Depends on pst_pkg.
//
// The block takes one item per millisecond tick (pin samples and host bus
// events) and answers each with exactly one result item: the status byte,
// the three LED levels, the host supply enable, the sticky standby request
// with its cause, and the button event of that tick. An item enters an input
// register, is worked on by one pass of short logic that also updates the
// supervisor state, and the result lands in an output register. While the
// result register is empty or being taken, a new item is accepted in every
// cycle, so the sustained rate is one item per clock; the result is computed
// from the input register and moves to the result register. When the result
// register is full and not taken, it holds and the input register still takes
// one more item before in_ready drops. The watchdog and low-battery limits
// are kept as tick counts, multiplied out from seconds when the configuration
// register is written, so each tick needs only a compare. The user must write
// configuration only while no item is in flight; the block does not enforce it.
// The configuration port is always ready and ignores writes past the last index.
module power_supervisor_tick_top #(
	parameter int TICKS_PER_SECOND  = pst_pkg::TICKS_PER_SECOND_DEF,
	parameter int SHORT_PRESS_MIN   = pst_pkg::SHORT_PRESS_MIN_DEF,
	parameter int LONG_PRESS_MIN    = pst_pkg::LONG_PRESS_MIN_DEF,
	parameter int SLOW_HALF_PERIOD  = pst_pkg::SLOW_HALF_PERIOD_DEF,
	parameter int FAST_HALF_PERIOD  = pst_pkg::FAST_HALF_PERIOD_DEF,
	parameter int BUTTON_ACTIVE_LOW = pst_pkg::BUTTON_ACTIVE_LOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pst_pkg::item_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pst_pkg::result_t                 out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pst_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pst_pkg::SEC_W-1:0]        cfg_data
);

	// Blink phase counters wrap at twice the half period.
	localparam int SLOW_W = (2 * SLOW_HALF_PERIOD > 2) ? $clog2(2 * SLOW_HALF_PERIOD) : 1;
	localparam int FAST_W = (2 * FAST_HALF_PERIOD > 2) ? $clog2(2 * FAST_HALF_PERIOD) : 1;
	localparam logic [SLOW_W-1:0] SLOW_HALF = SLOW_W'(SLOW_HALF_PERIOD);
	localparam logic [SLOW_W-1:0] SLOW_LAST = SLOW_W'(2 * SLOW_HALF_PERIOD - 1);
	localparam logic [FAST_W-1:0] FAST_HALF = FAST_W'(FAST_HALF_PERIOD);
	localparam logic [FAST_W-1:0] FAST_LAST = FAST_W'(2 * FAST_HALF_PERIOD - 1);

	localparam int ELAP_W  = pst_pkg::ELAP_W;
	localparam int TIMER_W = pst_pkg::TIMER_W;
	localparam int LIM_W   = pst_pkg::LIM_W;
	localparam logic [ELAP_W-1:0]  ELAP_MAX  = {ELAP_W{1'b1}};
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
	localparam logic [TIMER_W-1:0] SHORT_MIN = TIMER_W'(SHORT_PRESS_MIN);
	localparam logic [TIMER_W-1:0] LONG_MIN  = TIMER_W'(LONG_PRESS_MIN);
	localparam logic [LIM_W-1:0]   TPS       = LIM_W'(TICKS_PER_SECOND);
	localparam logic               ACT_LOW   = 1'(BUTTON_ACTIVE_LOW);

	// Configuration, limits already expressed in ticks.
	logic [LIM_W-1:0] wd_limit_q;
	logic [LIM_W-1:0] lb_limit_q;
	logic             en_bus_wd_q;
	logic             en_pin_wd_q;
	logic             en_lowbat_q;

	// Pipeline registers.
	pst_pkg::item_t   item_s1;
	logic             vld_s1;
	pst_pkg::result_t res_s2;
	logic             vld_s2;
	logic             advance;

	// Supervisor state.
	pst_pkg::button_mode_t mode_q,      mode_n;
	logic [TIMER_W-1:0]    timer_q,     timer_n;
	logic                  flag_q,      flag_n;
	logic                  led_fast_q,  led_fast_n;
	logic                  started_q,   started_n;
	logic                  standby_q,   standby_n;
	logic [1:0]            cause_q,     cause_n;
	logic [ELAP_W-1:0]     wd_elap_q,   wd_elap_n;
	logic                  lb_active_q, lb_active_n;
	logic [ELAP_W-1:0]     lb_elap_q,   lb_elap_n;
	logic [SLOW_W-1:0]     slow_ph_q,   slow_ph_n;
	logic [FAST_W-1:0]     fast_ph_q,   fast_ph_n;
	logic                  pwr_led_q,   pwr_led_n;
	logic                  chg_led_q,   chg_led_n;
	pst_pkg::result_t      res_n;

	function automatic logic [ELAP_W-1:0] sat_inc(input logic [ELAP_W-1:0] v);
		sat_inc = (v == ELAP_MAX) ? v : v + 1'b1;
	endfunction

	// Charger LED pattern from status bits 2..0; code zero keeps both levels.
	function automatic logic [1:0] charger_leds(input logic [2:0] code, input logic slow,
			input logic fast, input logic [1:0] cur);
		logic [1:0] r;
		case (code)
			3'd1, 3'd2: r = {fast, fast};
			3'd3:       r = 2'b11;
			3'd4:       r = {1'b0, fast};
			3'd5:       r = {1'b1, slow};
			3'd6:       r = 2'b00;
			3'd7:       r = 2'b10;
			default:    r = cur;
		endcase
		charger_leds = r;
	endfunction

	assign advance   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready  = !vld_s1 || advance;
	assign out_valid = vld_s2;
	assign out_data  = res_s2;
	assign cfg_ready = 1'b1;

	// Configuration registers; the seconds-to-ticks product is taken at write time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_limit_q  <= '0;
			lb_limit_q  <= LIM_W'(pst_pkg::LOWBAT_RESET_S) * TPS;
			en_bus_wd_q <= 1'b0;
			en_pin_wd_q <= 1'b0;
			en_lowbat_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (pst_pkg::cfg_index_t'(cfg_index))
				pst_pkg::CFG_WATCHDOG_TIMEOUT: wd_limit_q  <= LIM_W'(cfg_data) * TPS;
				pst_pkg::CFG_LOWBAT_TIMEOUT:   lb_limit_q  <= LIM_W'(cfg_data) * TPS;
				pst_pkg::CFG_EN_BUS_WATCHDOG:  en_bus_wd_q <= cfg_data[0];
				pst_pkg::CFG_EN_PIN_WATCHDOG:  en_pin_wd_q <= cfg_data[0];
				pst_pkg::CFG_EN_LOWBAT_SHDN:   en_lowbat_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Tick logic: one pass over the registered item and the current state.
	always_comb begin
		logic [7:0] stat;
		logic       low, slow, fast, pressed, st_led;
		logic [1:0] leds, ev, cause;

		pressed = item_s1.button_level ^ ACT_LOW;
		stat = {1'b0, item_s1.alarm_flag, 1'b0, item_s1.clock_initialized,
			item_s1.power_good2, item_s1.charger_stat2, item_s1.charger_stat1,
			item_s1.power_good};
		low  = (stat[2:0] == 3'b100);
		slow = (slow_ph_q >= SLOW_HALF);
		fast = (fast_ph_q >= FAST_HALF);
		ev     = pst_pkg::EVENT_NONE;
		cause  = pst_pkg::CAUSE_NONE;
		st_led = 1'b0;
		leds   = {pwr_led_q, chg_led_q};

		mode_n      = mode_q;
		timer_n     = timer_q;
		flag_n      = flag_q;
		led_fast_n  = led_fast_q;
		started_n   = started_q;
		standby_n   = standby_q;
		cause_n     = cause_q;
		wd_elap_n   = wd_elap_q;
		lb_active_n = lb_active_q;
		lb_elap_n   = lb_elap_q;
		pwr_led_n   = pwr_led_q;
		chg_led_n   = chg_led_q;

		slow_ph_n = (slow_ph_q == SLOW_LAST) ? '0 : slow_ph_q + 1'b1;
		fast_ph_n = (fast_ph_q == FAST_LAST) ? '0 : fast_ph_q + 1'b1;

		if (!standby_q) begin
			wd_elap_n = sat_inc(wd_elap_q);
			if (!started_q && low) begin
				leds = charger_leds(stat[2:0], slow, fast, {pwr_led_q, chg_led_q});
				{pwr_led_n, chg_led_n} = leds;
			end else begin
				started_n = 1'b1;
				case (mode_q)
					pst_pkg::MODE_PRESSED: begin
						timer_n = (timer_q == TIMER_MAX) ? timer_q : timer_q + 1'b1;
						if (pressed) begin
							if (timer_n > LONG_MIN) begin
								mode_n     = pst_pkg::MODE_HELD;
								led_fast_n = 1'b1;
							end
						end else if (timer_n > SHORT_MIN) begin
							mode_n = pst_pkg::MODE_IDLE;
							ev     = pst_pkg::EVENT_SHORT;
							flag_n = 1'b1;
						end
					end
					pst_pkg::MODE_HELD: begin
						if (!pressed) begin
							mode_n     = pst_pkg::MODE_IDLE;
							ev         = pst_pkg::EVENT_LONG;
							led_fast_n = 1'b0;
							cause      = pst_pkg::CAUSE_LONG_PRESS;
						end
					end
					default: begin
						mode_n = pressed ? pst_pkg::MODE_PRESSED : pst_pkg::MODE_IDLE;
						if (pressed)
							timer_n = '0;
					end
				endcase

				if (cause == pst_pkg::CAUSE_NONE) begin
					if (item_s1.bus_write_event && item_s1.clear_button_request)
						flag_n = 1'b0;
					if (en_bus_wd_q && (item_s1.bus_write_event || item_s1.bus_read_event))
						wd_elap_n = '0;
					if (en_pin_wd_q && item_s1.watchdog_pin)
						wd_elap_n = '0;
					st_led = led_fast_n ? fast : 1'b1;
					leds = charger_leds(stat[2:0], slow, fast, {pwr_led_q, chg_led_q});
					{pwr_led_n, chg_led_n} = leds;
					if ((en_bus_wd_q || en_pin_wd_q) && (LIM_W'(wd_elap_n) > wd_limit_q))
						cause = pst_pkg::CAUSE_WATCHDOG;
					if (lb_active_q)
						lb_elap_n = sat_inc(lb_elap_q);
					if (en_lowbat_q) begin
						if (!lb_active_q) begin
							if (low) begin
								lb_active_n = 1'b1;
								lb_elap_n   = '0;
							end
						end else if (!low) begin
							lb_active_n = 1'b0;
						end else if ((LIM_W'(lb_elap_n) > lb_limit_q) &&
								(cause == pst_pkg::CAUSE_NONE)) begin
							cause = pst_pkg::CAUSE_LOWBAT;
						end
					end
				end

				if (cause != pst_pkg::CAUSE_NONE) begin
					standby_n = 1'b1;
					cause_n   = cause;
					pwr_led_n = 1'b0;
					chg_led_n = 1'b0;
					st_led    = 1'b0;
				end
			end
		end

		res_n.status_byte     = {flag_n, stat[6:0]};
		res_n.status_led      = !standby_n && st_led;
		res_n.power_led       = !standby_n && pwr_led_n;
		res_n.charge_led      = !standby_n && chg_led_n;
		res_n.power_enable    = started_n && !standby_n;
		res_n.standby_request = standby_n;
		res_n.standby_cause   = cause_n;
		res_n.button_event    = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (advance)
				vld_s2 <= 1'b1;
			else if (out_ready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (advance)
			res_s2 <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= pst_pkg::MODE_IDLE;
			timer_q     <= '0;
			flag_q      <= 1'b0;
			led_fast_q  <= 1'b0;
			started_q   <= 1'b0;
			standby_q   <= 1'b0;
			cause_q     <= pst_pkg::CAUSE_NONE;
			wd_elap_q   <= '0;
			lb_active_q <= 1'b0;
			lb_elap_q   <= '0;
			slow_ph_q   <= '0;
			fast_ph_q   <= '0;
			pwr_led_q   <= 1'b0;
			chg_led_q   <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_n;
			timer_q     <= timer_n;
			flag_q      <= flag_n;
			led_fast_q  <= led_fast_n;
			started_q   <= started_n;
			standby_q   <= standby_n;
			cause_q     <= cause_n;
			wd_elap_q   <= wd_elap_n;
			lb_active_q <= lb_active_n;
			lb_elap_q   <= lb_elap_n;
			slow_ph_q   <= slow_ph_n;
			fast_ph_q   <= fast_ph_n;
			pwr_led_q   <= pwr_led_n;
			chg_led_q   <= chg_led_n;
		end
	end

endmodule

// ===== rtl/pst_checker.sv =====
// Port-level checks for the power supervisor tick block, bound to the top level.
// Depends on pst_pkg and power_supervisor_tick_top.
module pst_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input pst_pkg::result_t              out_data
);

	// A stalled result item must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// In standby every LED and the host supply are off and a cause is recorded.
	a_standby_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.standby_request |->
			!out_data.power_enable && !out_data.status_led && !out_data.power_led &&
			!out_data.charge_led && out_data.standby_cause != pst_pkg::CAUSE_NONE)
		else $error("standby with outputs active or no cause");

	// Outside standby no cause may be shown.
	a_cause_needs_standby: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.standby_request |->
			out_data.standby_cause == pst_pkg::CAUSE_NONE)
		else $error("standby cause without standby");

	// A long press always latches standby with the long press cause.
	a_long_press_latches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.button_event == pst_pkg::EVENT_LONG |->
			out_data.standby_request &&
			out_data.standby_cause == pst_pkg::CAUSE_LONG_PRESS)
		else $error("long press without standby");

	// Bit 5 of the status byte is never set.
	a_status_bit5: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_data.status_byte[5])
		else $error("status byte bit 5 set");

endmodule

bind power_supervisor_tick_top pst_checker u_pst_checker (.*);
